// ===== rtl/core/cmmc_pkg.sv =====
// Package for the channel min/max calibrator: action and status codes,
// field widths and the sequencer state type.
// No dependencies.
package cmmc_pkg;

    localparam int ACTION_W  = 2;
    localparam int CHAN_W    = 3;
    localparam int SAMPLE_W  = 16;
    localparam int STATUS_W  = 2;
    localparam int SPAN_W    = 16;

    localparam logic [SPAN_W-1:0] SPAN_RESET = 16'd4096;

    localparam logic [ACTION_W-1:0] ACT_START  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_RUN  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_RANGE = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_CHK_RD  = 5'b00010,
        S_CHK_EV  = 5'b00100,
        S_EMIT_RD = 5'b01000,
        S_EMIT_EV = 5'b10000
    } state_t;

endpackage

// ===== rtl/core/channel_min_max_calibrator.sv =====
// Top level of the channel min/max calibrator.
// Depends on cmmc_pkg and cmmc_ram.
//
// Start, sample, action 3 and a stop while not running are taken in idle; they may
// follow each other in consecutive cycles unless the output stalls. Each channel's
// {min, max} pair sits in one RAM entry; a sample is read in the accept cycle and
// written back in the next, with the last write forwarded to the following read. A
// stop while running walks the RAM through its single read port: a read and a
// span-check state per channel, ending with a no-range status at the first failing
// channel, then a read and an emit state per channel, held by output stalls.
// Per-entry valid bits stand in for clearing, so start and reset need no clearing pass.
module channel_min_max_calibrator #(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [cmmc_pkg::SPAN_W-1:0]         wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [cmmc_pkg::ACTION_W-1:0]       action,
    input  logic [cmmc_pkg::CHAN_W-1:0]         channel,
    input  logic [cmmc_pkg::SAMPLE_W-1:0]       sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [cmmc_pkg::STATUS_W-1:0]       status,
    output logic [cmmc_pkg::CHAN_W-1:0]         out_channel,
    output logic [cmmc_pkg::SAMPLE_W-1:0]       low_seen,
    output logic [cmmc_pkg::SAMPLE_W-1:0]       high_seen,
    output logic                                last
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ENT_W = 2 * SAMPLE_BITS;
    localparam int CMP_W = (SAMPLE_BITS > cmmc_pkg::SPAN_W) ? SAMPLE_BITS : cmmc_pkg::SPAN_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

    cmmc_pkg::state_t state_reg, state_next;

    logic [cmmc_pkg::SPAN_W-1:0] span_reg;
    logic                        running_reg, running_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [IDX_W-1:0]            rd_addr;
    logic [IDX_W-1:0]            rd_addr_q_reg;
    logic [CHANNELS-1:0]         valid_reg, valid_next;
    logic                        upd_vld_reg, upd_vld_next;
    logic [SAMPLE_BITS-1:0]      upd_sample_reg;
    logic                        fwd_valid_reg;
    logic [IDX_W-1:0]            fwd_ch_reg;
    logic [ENT_W-1:0]            fwd_data_reg;

    logic [ENT_W-1:0]            ram_rdata;
    logic [ENT_W-1:0]            ram_wdata;

    logic [SAMPLE_BITS-1:0]      eff_min, eff_max, eff_diff;
    logic [SAMPLE_BITS-1:0]      new_min, new_max;
    logic                        span_fail;

    logic                        accept;
    logic                        out_free;
    logic                        clr_all;
    logic                        ch_in_range;
    logic [IDX_W-1:0]            ch_addr;

    logic                        out_load;
    logic [cmmc_pkg::STATUS_W-1:0] ld_status;
    logic [cmmc_pkg::CHAN_W-1:0]   ld_ch;
    logic [cmmc_pkg::SAMPLE_W-1:0] ld_lo, ld_hi;
    logic                          ld_last;

    logic                          out_valid_reg;
    logic [cmmc_pkg::STATUS_W-1:0] status_reg;
    logic [cmmc_pkg::CHAN_W-1:0]   out_channel_reg;
    logic [cmmc_pkg::SAMPLE_W-1:0] low_seen_reg, high_seen_reg;
    logic                          last_reg;

    assign out_free    = !out_valid_reg || !out_stall;
    assign in_stall    = !((state_reg == cmmc_pkg::S_IDLE) && out_free);
    assign accept      = in_valid && !in_stall;
    assign ch_in_range = 32'(channel) < 32'(CHANNELS);
    assign ch_addr     = IDX_W'(channel);
    assign clr_all     = accept && (action == cmmc_pkg::ACT_START);

    cmmc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CHANNELS)
    ) u_store (
        .clk   (clk),
        .we    (upd_vld_reg),
        .waddr (rd_addr_q_reg),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // entry seen by the read issued last cycle: forwarded write, stored value,
    // or the cleared value when the entry was not written since start/reset
    always_comb
    begin
        if (fwd_valid_reg && (fwd_ch_reg == rd_addr_q_reg))
        begin
            {eff_min, eff_max} = fwd_data_reg;
        end
        else if (valid_reg[rd_addr_q_reg])
        begin
            {eff_min, eff_max} = ram_rdata;
        end
        else
        begin
            eff_min = '1;
            eff_max = '0;
        end
    end

    assign eff_diff  = eff_max - eff_min;
    assign span_fail = (eff_max < eff_min) || (CMP_W'(eff_diff) < CMP_W'(span_reg));
    assign new_min   = (upd_sample_reg < eff_min) ? upd_sample_reg : eff_min;
    assign new_max   = (upd_sample_reg > eff_max) ? upd_sample_reg : eff_max;
    assign ram_wdata = {new_min, new_max};

    always_comb
    begin
        valid_next = valid_reg;
        if (upd_vld_reg)
        begin
            valid_next[rd_addr_q_reg] = 1'b1;
        end
        if (clr_all)
        begin
            valid_next = '0;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        running_next = running_reg;
        upd_vld_next = 1'b0;
        rd_addr      = idx_reg;
        out_load     = 1'b0;
        ld_status    = cmmc_pkg::STAT_OK;
        ld_ch        = '0;
        ld_lo        = '0;
        ld_hi        = '0;
        ld_last      = 1'b1;
        unique case (state_reg)
            cmmc_pkg::S_IDLE:
            begin
                rd_addr = ch_addr;
                if (accept)
                begin
                    unique case (action)
                        cmmc_pkg::ACT_START:
                        begin
                            running_next = 1'b1;
                            out_load     = 1'b1;
                        end
                        cmmc_pkg::ACT_SAMPLE:
                        begin
                            out_load = 1'b1;
                            if (!running_reg)
                            begin
                                ld_status = cmmc_pkg::STAT_NOT_RUN;
                            end
                            else
                            begin
                                upd_vld_next = ch_in_range;
                            end
                        end
                        cmmc_pkg::ACT_STOP:
                        begin
                            if (!running_reg)
                            begin
                                out_load  = 1'b1;
                                ld_status = cmmc_pkg::STAT_NOT_RUN;
                            end
                            else
                            begin
                                running_next = 1'b0;
                                idx_next     = '0;
                                state_next   = cmmc_pkg::S_CHK_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            cmmc_pkg::S_CHK_RD:
            begin
                state_next = cmmc_pkg::S_CHK_EV;
            end
            cmmc_pkg::S_CHK_EV:
            begin
                if (span_fail)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        ld_status  = cmmc_pkg::STAT_NO_RANGE;
                        state_next = cmmc_pkg::S_IDLE;
                    end
                end
                else if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = cmmc_pkg::S_EMIT_RD;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = cmmc_pkg::S_CHK_RD;
                end
            end
            cmmc_pkg::S_EMIT_RD:
            begin
                state_next = cmmc_pkg::S_EMIT_EV;
            end
            cmmc_pkg::S_EMIT_EV:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    ld_ch    = cmmc_pkg::CHAN_W'(idx_reg);
                    ld_lo    = cmmc_pkg::SAMPLE_W'(eff_min);
                    ld_hi    = cmmc_pkg::SAMPLE_W'(eff_max);
                    ld_last  = (idx_reg == LAST_IDX);
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = cmmc_pkg::S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = cmmc_pkg::S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = cmmc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cmmc_pkg::S_IDLE;
            span_reg      <= cmmc_pkg::SPAN_RESET;
            running_reg   <= 1'b0;
            idx_reg       <= '0;
            valid_reg     <= '0;
            upd_vld_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            running_reg <= running_next;
            idx_reg     <= idx_next;
            valid_reg   <= valid_next;
            upd_vld_reg <= upd_vld_next;
            if (wr_en)
            begin
                span_reg <= wr_data;
            end
            if (clr_all)
            begin
                fwd_valid_reg <= 1'b0;
            end
            else if (upd_vld_reg)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_q_reg <= rd_addr;
        if (accept)
        begin
            upd_sample_reg <= SAMPLE_BITS'(sample);
        end
        if (upd_vld_reg)
        begin
            fwd_ch_reg   <= rd_addr_q_reg;
            fwd_data_reg <= ram_wdata;
        end
        if (out_load)
        begin
            status_reg      <= ld_status;
            out_channel_reg <= ld_ch;
            low_seen_reg    <= ld_lo;
            high_seen_reg   <= ld_hi;
            last_reg        <= ld_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_channel = out_channel_reg;
    assign low_seen    = low_seen_reg;
    assign high_seen   = high_seen_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_stop_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == cmmc_pkg::ACT_STOP)) |=> !running_reg)
        else $error("running still set after stop item");

    a_update_follows_sample: assert property (@(posedge clk) disable iff (!rst_n)
        upd_vld_reg |-> $past(accept && (action == cmmc_pkg::ACT_SAMPLE) && running_reg))
        else $error("store write without a preceding sample item");

    a_last_emit_returns: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == cmmc_pkg::S_EMIT_EV) && out_load && ld_last)
        |=> (state_reg == cmmc_pkg::S_IDLE))
        else $error("sequencer did not return to idle after last result");

    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != cmmc_pkg::S_IDLE) |-> !upd_vld_next)
        else $error("sample update issued during stop sweep");
`endif

endmodule

// ===== rtl/core/cmmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the per-channel extreme store; no dependencies.
module cmmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old entry when the same address is written
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
